@@ sv/rqf_pkg.sv @@
// shared types and constants for the ring queue fifo
package rqf_pkg;

   localparam int ITEM_BITS  = 32;
   localparam int COUNT_BITS = 5;
   localparam int CAP_BITS   = 5;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [ITEM_BITS-1:0] data_in;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [ITEM_BITS-1:0]  data_out;
      logic [COUNT_BITS-1:0] item_count;
      logic                  is_empty;
      logic                  is_full;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // capture request beat and read head slot
      logic commit;     // execute and register the result
      logic cfg_write;  // capacity register write
   } ctl_cmd_type;

endpackage

@@ sv/ring_queue_fifo.sv @@
// top level of the ring queue fifo
//
//   channel | ports                           | direction | payload
//   --------+---------------------------------+-----------+----------------------
//   request | req_valid req_ready req_data    | in        | opcode, data_in
//   result  | rsp_valid rsp_ready rsp_data    | out       | status, data, count, flags
//   config  | csr_valid csr_ready csr_data    | in        | capacity in use
//
// each request beat goes in two steps: capture with the head slot read, then execute;
// the next beat is taken only after execute; the registered slot memory read sets this.
// the result register lets the next request beat in while a result beat waits.
// execution stalls only while a waiting result beat is not taken.
// synchronous reset empties the queue and sets capacity to 16; no clearing pass,
// slot contents are left as they are.
module ring_queue_fifo #(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  rqf_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rqf_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rqf_pkg::CAP_BITS-1:0] csr_data
);

   rqf_pkg::ctl_cmd_type cmd;

   rqf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   rqf_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

endmodule

@@ sv/rqf_ctrl.sv @@
// controller state machine for the ring queue fifo
module rqf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               csr_valid,
   output logic               csr_ready,
   output rqf_pkg::ctl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // handshakes and commands
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_ready  = (state_ff == S_IDLE) && !csr_valid;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd           = '0;
      cmd.load      = req_valid && req_ready;
      cmd.cfg_write = csr_valid && csr_ready;
      cmd.commit    = (state_ff == S_EXEC) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.commit) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // an accepted beat always moves to execution
   a_load_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_EXEC)
      else $error("accepted beat did not enter execution");

   // a commit always leaves a result beat pending
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit without result beat");

   // no request or config beat taken while executing
   a_no_take_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> !cmd.load && !cmd.cfg_write)
      else $error("beat taken during execution");

endmodule

@@ sv/rqf_dpath.sv @@
// datapath of the ring queue fifo: slot memory, pointers, count, result register
module rqf_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rqf_pkg::ctl_cmd_type          cmd,
   input  rqf_pkg::req_type              req_data,
   input  logic [rqf_pkg::CAP_BITS-1:0]  csr_data,
   output rqf_pkg::rsp_type              rsp_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (PTR_W + 1 > rqf_pkg::CAP_BITS) ? PTR_W + 1 : rqf_pkg::CAP_BITS;
   localparam int CAP_MAX_I = (DEPTH > (2 ** rqf_pkg::CAP_BITS) - 1) ?
                              (2 ** rqf_pkg::CAP_BITS) - 1 : DEPTH;
   localparam logic [rqf_pkg::CAP_BITS-1:0] CAP_MAX = rqf_pkg::CAP_BITS'(CAP_MAX_I);
   localparam logic [rqf_pkg::CAP_BITS-1:0] CAP_MIN = rqf_pkg::CAP_BITS'(1);

   logic [rqf_pkg::ITEM_BITS-1:0]  mem [0:DEPTH-1];
   logic [rqf_pkg::ITEM_BITS-1:0]  rd_data_ff;
   logic [PTR_W-1:0]               head_ff, head_in;
   logic [PTR_W-1:0]               tail_ff, tail_in;
   logic [rqf_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [rqf_pkg::CAP_BITS-1:0]   cap_ff;
   rqf_pkg::opcode_type            op_ff;
   logic [rqf_pkg::ITEM_BITS-1:0]  word_ff;
   rqf_pkg::rsp_type               rsp_ff, rsp_in;
   logic [rqf_pkg::CAP_BITS-1:0]   cap_eff;
   logic                           full_now;
   logic                           empty_now;
   logic                           do_write;
   logic [PTR_W-1:0]               head_adv;
   logic [PTR_W-1:0]               tail_adv;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx,
                                                input logic [rqf_pkg::CAP_BITS-1:0] cap);
      logic [CW-1:0] nxt;
      nxt = CW'(idx) + CW'(1);
      if (nxt >= CW'(cap)) return '0;
      return nxt[PTR_W-1:0];
   endfunction

   // capacity clamped to the usable range
   always_comb begin
      if (cap_ff == '0) cap_eff = CAP_MIN;
      else if (cap_ff > CAP_MAX) cap_eff = CAP_MAX;
      else cap_eff = cap_ff;
   end

   assign full_now  = (rqf_pkg::CAP_BITS'(count_ff) >= cap_eff);
   assign empty_now = (count_ff == '0);
   assign head_adv  = advance(head_ff, cap_eff);
   assign tail_adv  = advance(tail_ff, cap_eff);
   assign do_write  = cmd.commit && (op_ff == rqf_pkg::OP_PUSH) && !full_now;

   // operation decode and pointer updates
   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      rsp_in          = rsp_ff;
      rsp_in.status   = rqf_pkg::ST_OK;
      rsp_in.data_out = '0;
      case (op_ff)
         rqf_pkg::OP_PUSH: begin
            if (full_now) begin
               rsp_in.status = rqf_pkg::ST_FULL;
            end else begin
               tail_in  = tail_adv;
               count_in = count_ff + rqf_pkg::COUNT_BITS'(1);
            end
         end
         rqf_pkg::OP_POP: begin
            if (empty_now) begin
               rsp_in.status = rqf_pkg::ST_EMPTY;
            end else begin
               rsp_in.data_out = rd_data_ff;
               head_in         = head_adv;
               count_in        = count_ff - rqf_pkg::COUNT_BITS'(1);
            end
         end
         rqf_pkg::OP_PEEK: begin
            if (empty_now) rsp_in.status = rqf_pkg::ST_EMPTY;
            else rsp_in.data_out = rd_data_ff;
         end
         rqf_pkg::OP_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: begin
            rsp_in.status = rqf_pkg::ST_OK;
         end
      endcase
      rsp_in.item_count = count_in;
      rsp_in.is_empty   = (count_in == '0);
      rsp_in.is_full    = (rqf_pkg::CAP_BITS'(count_in) >= cap_eff);
   end

   // control state: pointers, count, capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= rqf_pkg::CAP_BITS'(16);
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end else if (cmd.cfg_write && empty_now) begin
         cap_ff  <= csr_data;
         head_ff <= '0;
         tail_ff <= '0;
      end
   end

   // request capture and result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_data.opcode;
         word_ff <= req_data.data_in;
      end
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   // slot memory, head read registered at load
   always_ff @(posedge clock) begin
      if (do_write) mem[tail_ff] <= word_ff;
      if (cmd.load) rd_data_ff <= mem[head_ff];
   end

   assign rsp_data = rsp_ff;

   // count never exceeds the capacity in use
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rqf_pkg::CAP_BITS'(count_ff) <= cap_eff)
      else $error("stored count above capacity");

   // empty ring has coinciding pointers
   a_empty_ptr: assert property (@(posedge clock) disable iff (reset)
      empty_now |-> head_ff == tail_ff)
      else $error("pointers differ on empty ring");

   // a push that fits adds exactly one item
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      do_write |=> count_ff == $past(count_ff) + rqf_pkg::COUNT_BITS'(1))
      else $error("push did not add one item");

endmodule
